@@ rtl/ras_pkg.sv @@
package ras_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_DIV1,
        S_DIV2,
        S_DIV3,
        S_DECIDE,
        S_MOD,
        S_LREAD,
        S_LWAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CFG_AFFINITY = 2'd0,
        CFG_RANK     = 2'd1,
        CFG_DPH      = 2'd2,
        CFG_PPD      = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_NEAR  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // table sizes, tied to the field widths of the channels
    localparam int EXPERTS      = 64;
    localparam int MAX_REPLICAS = 8;
    localparam int POSITIONS    = 128;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [10:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [10:0] quot;
        logic [7:0]  rem;
    } t_div_rsp;

endpackage

@@ rtl/ras_if.sv @@
interface ras_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] layer;
    logic [6:0] position;
    logic       occupied;
    logic [5:0] expert;
    logic [3:0] replica_count;
    logic       layer_start;
    modport source (output valid, layer, position, occupied, expert, replica_count,
                    layer_start, input ready);
    modport sink (input valid, layer, position, occupied, expert, replica_count,
                  layer_start, output ready);
endinterface

interface ras_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] out_layer;
    logic [5:0] out_expert;
    logic [2:0] out_slot;
    logic [6:0] chosen_position;
    modport source (output valid, out_layer, out_expert, out_slot, chosen_position,
                    input ready);
    modport sink (input valid, out_layer, out_expert, out_slot, chosen_position,
                  output ready);
endinterface

@@ rtl/ras_div.sv @@
module ras_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ras_pkg::t_div_req i_req,
    output ras_pkg::t_div_rsp o_rsp
);
    // restoring divider, one quotient bit a cycle
    logic [10:0] r_quot;
    logic [8:0]  r_rem;
    logic [7:0]  r_div;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [8:0]  w_trial;
    logic [9:0]  w_diff;

    assign w_trial = {r_rem[7:0], r_quot[10]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd11;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[9]) begin
                    r_rem  <= w_diff[8:0];
                    r_quot <= {r_quot[9:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_quot <= {r_quot[9:0], 1'b0};
                end
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[7:0];

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_req.start |=> r_busy || r_done) else $error("divider lost");
    a_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == 4'd0 || $past(i_req.start) == 1'b0)
        else $error("divider count");
endmodule

@@ rtl/replica_affinity_selector.sv @@
// an item passes from the input registers through the state read to the result; the three position and host
// divisions come first when needed, and a near or far list pick adds rank mod length and a list read
// throughput: one item at a time; ready again in the cycle after the result registers, with
// the clear pass when layer_start is set and any output stall coming in between
// reset: synchronous active low; registers to defaults, then a clear of all 64 per-expert
// state entries and a pass through the read state before the input is ready
module replica_affinity_selector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ras_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ras_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ras_in_if.sink                           in_ch,
    ras_out_if.source                        out_ch
);
    localparam int EXPERTS      = ras_pkg::EXPERTS;
    localparam int MAX_REPLICAS = ras_pkg::MAX_REPLICAS;
    localparam int POSITIONS    = ras_pkg::POSITIONS;
    localparam int EW = (EXPERTS > 1) ? $clog2(EXPERTS) : 1;
    localparam int RW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam int CW = $clog2(MAX_REPLICAS + 1);
    localparam int LW = EW + RW;
    localparam int DEPTH = EXPERTS * MAX_REPLICAS;

    // configuration
    logic       r_aff;
    logic [3:0] r_rank;
    logic [4:0] r_dph;
    logic [7:0] r_ppd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aff  <= 1'b1;
            r_rank <= 4'd0;
            r_dph  <= 5'd8;
            r_ppd  <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (ras_pkg::t_cfg_idx'(i_cfg_idx))
                ras_pkg::CFG_AFFINITY: r_aff  <= i_cfg_data[0];
                ras_pkg::CFG_RANK:     r_rank <= i_cfg_data[3:0];
                ras_pkg::CFG_DPH:      r_dph  <= i_cfg_data[4:0];
                ras_pkg::CFG_PPD:      r_ppd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item registers
    ras_pkg::t_state r_state, n_state;
    logic [5:0]    r_layer;
    logic [6:0]    r_pos;
    logic          r_occ;
    logic [EW-1:0] r_exp;
    logic          r_exp_ok;
    logic [3:0]    r_cnt;
    logic [EW-1:0] r_clr, n_clr;
    logic [10:0]   r_dev, n_dev;
    logic [10:0]   r_host, n_host;
    logic          r_far, n_far;
    logic [RW-1:0] r_idx, n_idx;
    logic [2:0]    r_oslot, n_oslot;
    logic [6:0]    r_chosen, n_chosen;
    logic          r_use_list, n_use_list;
    logic          r_ovalid, n_ovalid;

    // output item register, parts the result from the next input item
    logic [5:0]    r_o_layer;
    logic [EW-1:0] r_o_exp;
    logic [2:0]    r_o_slot;
    logic [6:0]    r_o_pos;
    logic          out_load;
    logic [6:0]    w_pick;

    // per-expert state memory: status, near count, far count, slot count
    localparam int SW = 2 + 3 * CW;
    logic [SW-1:0] r_st_mem [EXPERTS];
    logic [SW-1:0] r_st_rd;
    logic          st_we;
    logic [EW-1:0] st_waddr;
    logic [SW-1:0] st_wdata;

    // candidate lists, near and far side by side
    logic [6:0]    r_near_mem [DEPTH];
    logic [6:0]    r_far_mem [DEPTH];
    logic [6:0]    r_near_rd, r_far_rd;
    logic          near_we, far_we;
    logic [LW-1:0] l_waddr, l_raddr;

    always_ff @(posedge i_clk) begin
        if (st_we) r_st_mem[st_waddr] <= st_wdata;
        r_st_rd <= r_st_mem[r_exp];
    end

    always_ff @(posedge i_clk) begin
        if (near_we) r_near_mem[l_waddr] <= r_pos;
        if (far_we)  r_far_mem[l_waddr]  <= r_pos;
        r_near_rd <= r_near_mem[l_raddr];
        r_far_rd  <= r_far_mem[l_raddr];
    end

    // list pick is only valid once the list read has landed
    assign w_pick = r_use_list ? (r_far ? r_far_rd : r_near_rd) : r_chosen;

    ras_pkg::t_div_req div_req;
    ras_pkg::t_div_rsp div_rsp;

    ras_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    logic [7:0] w_ppd, w_dph;
    assign w_ppd = (r_ppd == 8'd0) ? 8'd1 : r_ppd;
    assign w_dph = (r_dph == 5'd0) ? 8'd1 : {3'b0, r_dph};

    logic [1:0]    st_status;
    logic [CW-1:0] st_near, st_farc, st_slot;
    assign {st_status, st_near, st_farc, st_slot} = r_st_rd;

    // list length after the append, if any, kept as the mod divisor for the read index
    logic [CW-1:0] r_len, n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ras_pkg::S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_occ    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            if (in_ch.valid && in_ch.ready) begin
                r_layer  <= in_ch.layer;
                r_pos    <= in_ch.position;
                r_occ    <= in_ch.occupied;
                r_exp    <= in_ch.expert[EW-1:0];
                r_exp_ok <= ({2'b0, in_ch.expert} < 8'(EXPERTS))
                            && ({1'b0, in_ch.position} < 8'(POSITIONS));
                r_cnt    <= in_ch.replica_count;
            end
        end
        r_dev      <= n_dev;
        r_host     <= n_host;
        r_far      <= n_far;
        r_idx      <= n_idx;
        r_oslot    <= n_oslot;
        r_chosen   <= n_chosen;
        r_use_list <= n_use_list;
        r_len      <= n_len;
        if (out_load) begin
            r_o_layer <= r_layer;
            r_o_exp   <= r_exp;
            r_o_slot  <= r_oslot;
            r_o_pos   <= w_pick;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_dev      = r_dev;
        n_host     = r_host;
        n_far      = r_far;
        n_idx      = r_idx;
        n_oslot    = r_oslot;
        n_chosen   = r_chosen;
        n_use_list = r_use_list;
        n_len      = r_len;
        n_ovalid   = r_ovalid;
        out_load   = 1'b0;
        div_req    = '0;
        st_we      = 1'b0;
        st_waddr   = r_exp;
        st_wdata   = r_st_rd;
        near_we    = 1'b0;
        far_we     = 1'b0;
        l_waddr    = {r_exp, st_near[RW-1:0]};
        l_raddr    = {r_exp, r_idx};
        in_ch.ready = 1'b0;
        if (out_ch.valid && out_ch.ready) n_ovalid = 1'b0;

        unique case (r_state)
            ras_pkg::S_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                    n_state = in_ch.layer_start ? ras_pkg::S_CLEAR : ras_pkg::S_READ;
                n_clr = '0;
            end
            ras_pkg::S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = '0;
                n_clr    = r_clr + 1'b1;
                // after reset r_occ is low, so the read state drops straight to idle
                if (32'(r_clr) == EXPERTS - 1)
                    n_state = ras_pkg::S_READ;
            end
            ras_pkg::S_READ: begin
                // state read issued; item checks
                if (!r_occ || !r_exp_ok) begin
                    n_state = ras_pkg::S_IDLE;
                end else if (!r_aff || r_cnt == 4'd1) begin
                    n_state = ras_pkg::S_DECIDE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {4'b0, r_pos};
                    div_req.divisor  = w_ppd;
                    n_state = ras_pkg::S_DIV1;
                end
            end
            ras_pkg::S_DIV1: if (div_rsp.done) begin
                n_dev = div_rsp.quot;
                div_req.start    = 1'b1;
                div_req.dividend = div_rsp.quot;
                div_req.divisor  = w_dph;
                n_state = ras_pkg::S_DIV2;
            end
            ras_pkg::S_DIV2: if (div_rsp.done) begin
                n_host = div_rsp.quot;
                div_req.start    = 1'b1;
                div_req.dividend = {7'b0, r_rank};
                div_req.divisor  = w_dph;
                n_state = ras_pkg::S_DIV3;
            end
            ras_pkg::S_DIV3: if (div_rsp.done) begin
                n_far   = (r_host != div_rsp.quot);
                n_state = ras_pkg::S_DECIDE;
            end
            ras_pkg::S_DECIDE: begin
                n_use_list = 1'b0;
                n_oslot    = 3'd0;
                n_chosen   = r_pos;
                if (!r_aff) begin
                    if (32'(st_slot) >= MAX_REPLICAS) begin
                        n_state = ras_pkg::S_IDLE;
                    end else begin
                        n_oslot  = 3'(st_slot);
                        st_we    = 1'b1;
                        st_wdata = {st_status, st_near, st_farc, st_slot + 1'b1};
                        n_state  = ras_pkg::S_OUT;
                    end
                end else if (r_cnt == 4'd1) begin
                    st_we    = 1'b1;
                    st_wdata = {ras_pkg::ST_NEAR, st_near, st_farc, st_slot};
                    n_state  = ras_pkg::S_OUT;
                end else if (st_status == ras_pkg::ST_FINAL) begin
                    n_state = ras_pkg::S_IDLE;
                end else if (r_dev == {7'b0, r_rank}) begin
                    st_we    = 1'b1;
                    st_wdata = {ras_pkg::ST_FINAL, st_near, st_farc, st_slot};
                    n_state  = ras_pkg::S_OUT;
                end else if (!r_far) begin
                    n_len = st_near;
                    if (32'(st_near) < MAX_REPLICAS) begin
                        near_we = 1'b1;
                        n_len   = st_near + 1'b1;
                    end
                    st_we      = 1'b1;
                    st_wdata   = {ras_pkg::ST_NEAR, n_len, st_farc, st_slot};
                    n_use_list = 1'b1;
                    n_state    = ras_pkg::S_MOD;
                end else if (st_status == ras_pkg::ST_NONE) begin
                    l_waddr = {r_exp, st_farc[RW-1:0]};
                    n_len = st_farc;
                    if (32'(st_farc) < MAX_REPLICAS) begin
                        far_we = 1'b1;
                        n_len  = st_farc + 1'b1;
                    end
                    st_we      = 1'b1;
                    st_wdata   = {st_status, st_near, n_len, st_slot};
                    n_use_list = 1'b1;
                    n_state    = ras_pkg::S_MOD;
                end else begin
                    n_state = ras_pkg::S_IDLE;
                end
            end
            ras_pkg::S_MOD: begin
                div_req.start    = 1'b1;
                div_req.dividend = {7'b0, r_rank};
                div_req.divisor  = 8'(r_len);
                n_state = ras_pkg::S_LREAD;
            end
            ras_pkg::S_LREAD: if (div_rsp.done) begin
                n_idx   = div_rsp.rem[RW-1:0];
                n_state = ras_pkg::S_LWAIT;
            end
            ras_pkg::S_LWAIT: begin
                // list read at the picked index lands for the output state
                n_state = ras_pkg::S_OUT;
            end
            ras_pkg::S_OUT: begin
                if (!r_ovalid || out_ch.ready) begin
                    out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ras_pkg::S_IDLE;
                end
            end
            default: n_state = ras_pkg::S_IDLE;
        endcase
    end

    assign out_ch.valid           = r_ovalid;
    assign out_ch.out_layer       = r_o_layer;
    assign out_ch.out_expert      = 6'(r_o_exp);
    assign out_ch.out_slot        = r_o_slot;
    assign out_ch.chosen_position = r_o_pos;

    // a new item only comes in while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == ras_pkg::S_IDLE) else $error("ready outside idle");
    // output item holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(r_o_pos)
        && $stable(r_o_layer) && $stable(r_o_exp) && $stable(r_o_slot))
        else $error("output item changed under stall");
    // list pick only after a non-empty list
    a_mod_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ras_pkg::S_MOD |-> r_len != '0) else $error("pick from empty list");
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int N_EXPERTS  = 64;
    localparam int MAX_REPL   = 8;
    localparam int STALL_LEN  = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 150;

    typedef struct {
        logic [5:0] layer;
        logic [6:0] position;
        logic       occupied;
        logic [5:0] expert;
        logic [3:0] replica_count;
        logic       layer_start;
    } t_item;

    typedef struct {
        logic [5:0] layer;
        logic [5:0] expert;
        logic [2:0] slot;
        logic [6:0] position;
    } t_sel_write;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ras_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ras_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ras_in_if  in_ch ();
    ras_out_if out_ch ();

    replica_affinity_selector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // shadow copy of registers and per-expert state
    logic       m_affinity;
    logic [3:0] m_rank;
    logic [4:0] m_dph;
    logic [7:0] m_ppd;
    logic [1:0] m_status [N_EXPERTS];
    logic [6:0] m_near   [N_EXPERTS*MAX_REPL];
    logic [6:0] m_far    [N_EXPERTS*MAX_REPL];
    int         m_ncnt   [N_EXPERTS];
    int         m_fcnt   [N_EXPERTS];
    int         m_scnt   [N_EXPERTS];

    t_item      pending_items [$];
    t_sel_write expected_writes [$];
    t_item      drv_item;
    int         errors = 0;
    bit         idle_en = 1;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         stall_left = 0;
    bit         stalled_once = 0;
    int         writes_seen = 0;
    int         quiet_cycles = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic void clear_experts();
        for (int e = 0; e < N_EXPERTS; e++) begin
            m_status[e] = ras_pkg::ST_NONE;
            m_ncnt[e] = 0;
            m_fcnt[e] = 0;
            m_scnt[e] = 0;
        end
    endfunction

    // append to a candidate list when there is room, then pick by rank
    function automatic logic [6:0] pick_candidate(bit use_far, int e, logic [6:0] pos);
        int n;
        n = use_far ? m_fcnt[e] : m_ncnt[e];
        if (n < MAX_REPL) begin
            if (use_far) m_far[e*MAX_REPL+n] = pos;
            else m_near[e*MAX_REPL+n] = pos;
            n++;
            if (use_far) m_fcnt[e] = n;
            else m_ncnt[e] = n;
        end
        return use_far ? m_far[e*MAX_REPL + (int'(m_rank) % n)]
                       : m_near[e*MAX_REPL + (int'(m_rank) % n)];
    endfunction

    // work out the selector write caused by one accepted item, if any
    function automatic void predict_selection(t_item it);
        t_sel_write w;
        int e, ppd, dph, dev, host, my_host;
        bit emit;
        e = int'(it.expert);
        emit = 1;
        if (it.layer_start) clear_experts();
        if (!it.occupied) return;
        w.layer = it.layer;
        w.expert = it.expert;
        w.slot = 3'd0;
        w.position = it.position;
        if (!m_affinity) begin
            if (m_scnt[e] >= MAX_REPL) return;
            w.slot = m_scnt[e][2:0];
            m_scnt[e]++;
        end else if (it.replica_count == 4'd1) begin
            m_status[e] = ras_pkg::ST_NEAR;
        end else begin
            ppd = (m_ppd == 0) ? 1 : int'(m_ppd);
            dph = (m_dph == 0) ? 1 : int'(m_dph);
            dev = int'(it.position) / ppd;
            host = dev / dph;
            my_host = int'(m_rank) / dph;
            if (m_status[e] == ras_pkg::ST_FINAL) return;
            if (dev == int'(m_rank)) begin
                m_status[e] = ras_pkg::ST_FINAL;
            end else if (host == my_host) begin
                w.position = pick_candidate(0, e, it.position);
                m_status[e] = ras_pkg::ST_NEAR;
            end else if (m_status[e] == ras_pkg::ST_NONE) begin
                w.position = pick_candidate(1, e, it.position);
            end else begin
                emit = 0;
            end
        end
        if (emit) expected_writes.insert(expected_writes.size(), w);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // driver: offers pending items, with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.layer <= '0;
            in_ch.position <= '0;
            in_ch.occupied <= 1'b0;
            in_ch.expert <= '0;
            in_ch.replica_count <= '0;
            in_ch.layer_start <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_selection(drv_item);
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0 && idle_en
                             && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 4);
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    drv_item = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.layer <= drv_item.layer;
                    in_ch.position <= drv_item.position;
                    in_ch.occupied <= drv_item.occupied;
                    in_ch.expert <= drv_item.expert;
                    in_ch.replica_count <= drv_item.replica_count;
                    in_ch.layer_start <= drv_item.layer_start;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stalls, one long hold-off, field-by-field compare
    always @(posedge i_clk) begin
        t_sel_write w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                writes_seen++;
                if (expected_writes.size() == 0) begin
                    report_mismatch("selector write with none expected");
                end else begin
                    w = expected_writes.pop_front();
                    if (out_ch.out_layer !== w.layer)
                        report_mismatch($sformatf("layer %0d, want %0d",
                                                  out_ch.out_layer, w.layer));
                    if (out_ch.out_expert !== w.expert)
                        report_mismatch($sformatf("expert %0d, want %0d",
                                                  out_ch.out_expert, w.expert));
                    if (out_ch.out_slot !== w.slot)
                        report_mismatch($sformatf("slot %0d, want %0d",
                                                  out_ch.out_slot, w.slot));
                    if (out_ch.chosen_position !== w.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  out_ch.chosen_position, w.position));
                end
            end
            // long hold-off so the block fills and stalls its input
            if (!stalled_once && writes_seen == 100) begin
                stalled_once = 1;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[replica_affinity_selector] ERROR");
            $finish;
        end
    end

    task automatic write_reg(ras_pkg::t_cfg_idx idx, logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            ras_pkg::CFG_AFFINITY: m_affinity = value[0];
            ras_pkg::CFG_RANK:     m_rank = value[3:0];
            ras_pkg::CFG_DPH:      m_dph = value[4:0];
            ras_pkg::CFG_PPD:      m_ppd = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic aff, logic [3:0] rank, logic [4:0] dph, logic [7:0] ppd);
        write_reg(ras_pkg::CFG_AFFINITY, {7'd0, aff});
        write_reg(ras_pkg::CFG_RANK, {4'd0, rank});
        write_reg(ras_pkg::CFG_DPH, {3'd0, dph});
        write_reg(ras_pkg::CFG_PPD, ppd);
    endtask

    // block is idle: nothing queued, nothing offered, nothing expected, plus settle time
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_writes.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_item(int layer, int pos, bit occ, int e, int cnt, bit start);
        t_item it;
        it.layer = 6'(layer);
        it.position = 7'(pos);
        it.occupied = occ;
        it.expert = 6'(e);
        it.replica_count = 4'(cnt);
        it.layer_start = start;
        pending_items.insert(pending_items.size(), it);
    endtask

    // one layer scan: ascending positions over a small pool of experts,
    // replica counts matching the layer, with some noise mixed in
    task automatic gen_layer(int npos);
        t_item layer_items [$];
        int    per_expert [N_EXPERTS];
        int    layer, base, pool, pos;
        t_item it;
        layer = $urandom_range(0, 63);
        base = $urandom_range(0, N_EXPERTS - 1);
        pool = $urandom_range(1, 8);
        pos = $urandom_range(0, 3);
        for (int e = 0; e < N_EXPERTS; e++) per_expert[e] = 0;
        while (pos < 128 && layer_items.size() < npos) begin
            it.layer = 6'(layer);
            it.position = 7'(pos);
            it.occupied = ($urandom_range(0, 11) != 0);
            it.expert = 6'((base + $urandom_range(0, pool - 1)) % N_EXPERTS);
            it.layer_start = (layer_items.size() == 0);
            if (it.occupied) per_expert[it.expert]++;
            layer_items.insert(layer_items.size(), it);
            pos += $urandom_range(1, 6);
        end
        foreach (layer_items[k]) begin
            it = layer_items[k];
            it.replica_count = 4'((per_expert[it.expert] > 8) ? 8 : per_expert[it.expert]);
            if ($urandom_range(0, 9) == 0) it.replica_count = 4'($urandom_range(0, 8));
            if ($urandom_range(0, 40) == 0) it.layer_start = 1'b1;
            pending_items.insert(pending_items.size(), it);
        end
    endtask

    task automatic random_phase(int items);
        int goal;
        goal = pending_items.size() + items;
        while (pending_items.size() < goal)
            gen_layer(($urandom_range(0, 7) == 0) ? 128 : $urandom_range(6, 40));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        m_affinity = 1'b1;
        m_rank = 4'd0;
        m_dph = 5'd8;
        m_ppd = 8'd8;
        clear_experts();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset settings: rank 0, 8 devices a host, 8 positions a device
        push_item(5, 0, 1, 0, 1, 1);        // single replica
        push_item(5, 1, 0, 9, 3, 0);        // empty position
        push_item(5, 3, 1, 1, 3, 0);        // local replica, final
        push_item(5, 30, 1, 1, 3, 0);       // after final: nothing
        push_item(5, 9, 1, 2, 2, 0);        // same host
        push_item(5, 100, 1, 2, 2, 0);      // distant after near: nothing
        push_item(5, 64, 1, 3, 3, 0);       // distant candidates
        push_item(5, 72, 1, 3, 3, 0);
        push_item(5, 80, 1, 3, 3, 0);
        for (int p = 10; p < 19; p++)
            push_item(5, p, 1, 4, 8, 0);    // nine near replicas overflow the list
        push_item(5, 127, 1, 63, 0, 0);     // zero count, top position and expert
        push_item(63, 120, 1, 63, 15, 1);   // all-ones layer, expert and count with a new layer
        drain();

        set_regs(1'b1, 4'd15, 5'd16, 8'd128);
        random_phase(90);
        drain();
        set_regs(1'b1, 4'd5, 5'd1, 8'd1);
        random_phase(90);
        drain();
        set_regs(1'b0, 4'd3, 5'd4, 8'd8);
        random_phase(100);
        drain();
        set_regs(1'b1, 4'd9, 5'd2, 8'd8);
        random_phase(90);
        drain();
        set_regs(1'b1, 4'($urandom_range(0, 15)), 5'($urandom_range(1, 16)),
                 8'($urandom_range(1, 16)));
        random_phase(80);
        drain();
        idle_en = 0;
        set_regs(1'b1, 4'd10, 5'd8, 8'd4);
        random_phase(70);
        drain();

        if (expected_writes.size() != 0)
            report_mismatch("selector writes still expected at end");
        if (errors == 0)
            $display("[replica_affinity_selector] OK");
        else
            $display("[replica_affinity_selector] ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/ras_pkg.sv
rtl/ras_if.sv
rtl/ras_div.sv
rtl/replica_affinity_selector.sv
bench/testbench.sv
